@@ hdl/kll_pkg.sv @@
// Shared types and constants for the k-means clustering block.
// Used by kmeans_lloyd_clustering and the testbench; depends on nothing else.
package kll_pkg;

  localparam int unsigned MaxPoints   = 1024;
  localparam int unsigned MaxClusters = 16;
  localparam int unsigned MaxDims     = 16;

  localparam int unsigned PtAw   = $clog2(MaxPoints * MaxDims);
  localparam int unsigned CenAw  = $clog2(MaxClusters * MaxDims);
  localparam int unsigned PidxW  = $clog2(MaxPoints);
  localparam int unsigned CidxW  = $clog2(MaxClusters);
  localparam int unsigned DidxW  = $clog2(MaxDims);
  localparam int unsigned CntW   = 11;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUM_POINTS   = 2'd0;
  localparam logic [1:0] CFG_NUM_CLUSTERS = 2'd1;
  localparam logic [1:0] CFG_NUM_DIMS     = 2'd2;
  localparam logic [1:0] CFG_MAX_ITER     = 2'd3;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_SELECT = 2'd1,
    ACT_START  = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef struct packed {
    action_e            action;
    logic signed [31:0] coordinate;
    logic [9:0]         point_index;
    logic [3:0]         cluster_slot;
  } item_t;

  typedef struct packed {
    logic [3:0] assigned_cluster;
    logic [9:0] read_point;
  } result_t;

  // Tag that follows one distance term down the assignment pipeline
  typedef struct packed {
    logic             first;
    logic             last;
    logic             last_c;
    logic [CidxW-1:0] c;
    logic [PidxW-1:0] p;
  } asg_tag_t;

endpackage

@@ hdl/kmeans_lloyd_clustering.sv @@
// Lloyd k-means clustering block: point, centroid, sum and assignment memories.
// Depends on kll_pkg and kll_div.
// Load and read words: one per cycle while idle; a read result strobes in the cycle after its word is accepted.
// Select copies num_dims coordinates into the chosen centroid slot. Start runs rounds of assignment, zeroing,
//   accumulation and update, with a divide for each dimension of every nonempty cluster.
// Reset: a sweep zeroes all 1024 assignment memory entries with busy high; results never stall.
module kmeans_lloyd_clustering (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  kll_pkg::item_t  item_i,
  output logic            res_valid_o,
  output kll_pkg::result_t res_o,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_idx_i,
  input  logic [15:0]     cfg_data_i
);

  typedef enum logic [15:0] {
    ST_CLEAR     = 16'h0001,
    ST_IDLE      = 16'h0002,
    ST_SELECT    = 16'h0004,
    ST_SEL_DRAIN = 16'h0008,
    ST_ASSIGN    = 16'h0010,
    ST_ASG_DRAIN = 16'h0020,
    ST_ZERO      = 16'h0040,
    ST_ACC_A     = 16'h0080,
    ST_ACC_W     = 16'h0100,
    ST_ACC_J     = 16'h0200,
    ST_ACC_DRAIN = 16'h0400,
    ST_UPD_RD    = 16'h0800,
    ST_UPD_GO    = 16'h1000,
    ST_UPD_DIV   = 16'h2000,
    ST_UPD_WR    = 16'h4000,
    ST_ITER_END  = 16'h8000
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [10:0] np_q;
  logic [4:0]  nc_q;
  logic [4:0]  nd_q;
  logic [15:0] mi_q;

  // Counters
  logic [kll_pkg::PtAw-1:0]  cursor_q;
  logic [kll_pkg::PidxW-1:0] clr_q;
  logic [kll_pkg::PidxW-1:0] p_q;
  logic [kll_pkg::CidxW-1:0] c_q;
  logic [kll_pkg::DidxW-1:0] j_q;
  logic [15:0]               it_q;
  logic [kll_pkg::PtAw-1:0]  pbase_q;
  logic [kll_pkg::PtAw-1:0]  sbase_q;
  logic [kll_pkg::CidxW-1:0] slot_q;
  logic                      same_q;

  // Clamped sizes
  logic [10:0] n_w, n_m1;
  logic [4:0]  k_w, k_m1, d_w, d_m1;
  logic [kll_pkg::PidxW-1:0] n_last;
  logic [kll_pkg::CidxW-1:0] k_last;
  logic [kll_pkg::DidxW-1:0] d_last;
  logic j_last, c_last, p_last;

  logic accept;
  logic [14:0] sel_prod;

  // Memories
  logic signed [31:0] pt_mem  [kll_pkg::MaxPoints*kll_pkg::MaxDims];
  logic signed [31:0] cen_mem [kll_pkg::MaxClusters*kll_pkg::MaxDims];
  logic signed [63:0] sum_mem [kll_pkg::MaxClusters*kll_pkg::MaxDims];
  logic [3:0]         asg_mem [kll_pkg::MaxPoints];
  logic [kll_pkg::CntW-1:0] cnt_q [kll_pkg::MaxClusters];

  logic                      pt_we;
  logic [kll_pkg::PtAw-1:0]  pt_wa, pt_ra;
  logic signed [31:0]        pt_rd_q;
  logic                      cen_we;
  logic [kll_pkg::CenAw-1:0] cen_wa, cen_ra;
  logic signed [31:0]        cen_wd, cen_rd_q;
  logic                      sum_we;
  logic [kll_pkg::CenAw-1:0] sum_wa, sum_ra;
  logic signed [63:0]        sum_wd, sum_rd_q;
  logic                      asg_we;
  logic [kll_pkg::PidxW-1:0] asg_wa, asg_ra;
  logic [3:0]                asg_wd, asg_rd_q;

  // Pipelines
  logic                      selv_q;
  logic [kll_pkg::CenAw-1:0] selwa_q;
  logic                      accv_q;
  logic [kll_pkg::CenAw-1:0] accwa_q;
  logic [kll_pkg::CidxW-1:0] a_q;
  logic                      s1v_q, s2v_q, s3v_q;
  kll_pkg::asg_tag_t         t1_q, t2_q, t3_q;
  logic [31:0]               mag_q;
  logic [63:0]               sq_q;
  logic [63:0]               acc_q, best_q;
  logic [kll_pkg::CidxW-1:0] bi_q;
  logic signed [32:0]        diff;
  logic [32:0]               mag_w;
  logic [64:0]               acc_sum;
  logic [63:0]               acc_sat;
  logic                      better;
  logic [kll_pkg::CidxW-1:0] win_c;

  // Update
  logic [kll_pkg::CidxW-1:0] cnt_ix;
  logic [kll_pkg::CntW-1:0]  cnt_rd;
  logic signed [31:0]        cen_old_q;
  logic signed [31:0]        m_q;
  logic                      div_start, div_done;
  logic signed [63:0]        div_quot;

  logic                      res_valid_q;
  logic [9:0]                res_pt_q;

  // Clamp sizes to their legal ranges
  always_comb begin
    if (np_q == 11'd0) begin
      n_w = 11'd1;
    end else if (np_q > 11'(kll_pkg::MaxPoints)) begin
      n_w = 11'(kll_pkg::MaxPoints);
    end else begin
      n_w = np_q;
    end
    if (nc_q == 5'd0) begin
      k_w = 5'd1;
    end else if (nc_q > 5'(kll_pkg::MaxClusters)) begin
      k_w = 5'(kll_pkg::MaxClusters);
    end else begin
      k_w = nc_q;
    end
    if (nd_q == 5'd0) begin
      d_w = 5'd1;
    end else if (nd_q > 5'(kll_pkg::MaxDims)) begin
      d_w = 5'(kll_pkg::MaxDims);
    end else begin
      d_w = nd_q;
    end
    n_m1   = n_w - 11'd1;
    k_m1   = k_w - 5'd1;
    d_m1   = d_w - 5'd1;
    n_last = n_m1[kll_pkg::PidxW-1:0];
    k_last = k_m1[kll_pkg::CidxW-1:0];
    d_last = d_m1[kll_pkg::DidxW-1:0];
    j_last = j_q == d_last;
    c_last = c_q == k_last;
    p_last = p_q == n_last;
  end

  assign busy_o   = state_q != ST_IDLE;
  assign accept   = start_i && !busy_o;
  assign sel_prod = 15'(item_i.point_index) * 15'(d_w);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && item_i.action == kll_pkg::ACT_SELECT) begin
          state_d = ST_SELECT;
        end else if (accept && item_i.action == kll_pkg::ACT_START) begin
          state_d = (mi_q == 16'd0) ? ST_IDLE : ST_ASSIGN;
        end
      end
      ST_SELECT: begin
        if (j_last) state_d = ST_SEL_DRAIN;
      end
      ST_SEL_DRAIN: state_d = ST_IDLE;
      ST_ASSIGN: begin
        if (j_last && c_last && p_last) state_d = ST_ASG_DRAIN;
      end
      ST_ASG_DRAIN: begin
        if (!(s1v_q || s2v_q || s3v_q)) state_d = ST_ZERO;
      end
      ST_ZERO: begin
        if (j_last && c_last) state_d = ST_ACC_A;
      end
      ST_ACC_A: state_d = ST_ACC_W;
      ST_ACC_W: state_d = ST_ACC_J;
      ST_ACC_J: begin
        if (j_last) state_d = p_last ? ST_ACC_DRAIN : ST_ACC_A;
      end
      ST_ACC_DRAIN: state_d = ST_UPD_RD;
      ST_UPD_RD:    state_d = ST_UPD_GO;
      ST_UPD_GO: begin
        state_d = (cnt_rd == '0) ? ST_UPD_WR : ST_UPD_DIV;
      end
      ST_UPD_DIV: begin
        if (div_done) state_d = ST_UPD_WR;
      end
      ST_UPD_WR: begin
        state_d = (j_last && c_last) ? ST_ITER_END : ST_UPD_RD;
      end
      ST_ITER_END: begin
        state_d = (same_q || ({1'b0, it_q} + 17'd1 >= {1'b0, mi_q})) ? ST_IDLE : ST_ASSIGN;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      np_q        <= 11'd1;
      nc_q        <= 5'd1;
      nd_q        <= 5'd1;
      mi_q        <= 16'd100;
      cursor_q    <= '0;
      clr_q       <= '0;
      p_q         <= '0;
      c_q         <= '0;
      j_q         <= '0;
      it_q        <= '0;
      pbase_q     <= '0;
      same_q      <= 1'b1;
      selv_q      <= 1'b0;
      accv_q      <= 1'b0;
      s1v_q       <= 1'b0;
      s2v_q       <= 1'b0;
      s3v_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      selv_q      <= state_q == ST_SELECT;
      accv_q      <= state_q == ST_ACC_J;
      s1v_q       <= state_q == ST_ASSIGN;
      s2v_q       <= s1v_q;
      s3v_q       <= s2v_q;
      res_valid_q <= accept && item_i.action == kll_pkg::ACT_READ;

      // Take register writes at any time
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          kll_pkg::CFG_NUM_POINTS:   np_q <= cfg_data_i[10:0];
          kll_pkg::CFG_NUM_CLUSTERS: nc_q <= cfg_data_i[4:0];
          kll_pkg::CFG_NUM_DIMS:     nd_q <= cfg_data_i[4:0];
          kll_pkg::CFG_MAX_ITER:     mi_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (accept && item_i.action == kll_pkg::ACT_LOAD) begin
        cursor_q <= cursor_q + 1'b1;
      end

      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: begin
          p_q     <= '0;
          c_q     <= '0;
          j_q     <= '0;
          it_q    <= '0;
          pbase_q <= '0;
        end
        ST_SELECT: j_q <= j_last ? '0 : j_q + 1'b1;
        ST_ASSIGN: begin
          // Advance dimension, then cluster, then point
          if (j_last) begin
            j_q <= '0;
            if (c_last) begin
              c_q     <= '0;
              p_q     <= p_q + 1'b1;
              pbase_q <= pbase_q + kll_pkg::PtAw'(d_w);
            end else begin
              c_q <= c_q + 1'b1;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_ASG_DRAIN: begin
          p_q     <= '0;
          c_q     <= '0;
          j_q     <= '0;
          pbase_q <= '0;
        end
        ST_ZERO: begin
          if (j_last) begin
            j_q <= '0;
            c_q <= c_last ? '0 : c_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_ACC_J: begin
          if (j_last) begin
            j_q     <= '0;
            p_q     <= p_q + 1'b1;
            pbase_q <= pbase_q + kll_pkg::PtAw'(d_w);
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_ACC_DRAIN: begin
          p_q     <= '0;
          c_q     <= '0;
          j_q     <= '0;
          pbase_q <= '0;
          same_q  <= 1'b1;
        end
        ST_UPD_WR: begin
          if (m_q != cen_old_q) same_q <= 1'b0;
          if (j_last) begin
            j_q <= '0;
            c_q <= c_last ? '0 : c_q + 1'b1;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_ITER_END: begin
          it_q    <= it_q + 1'b1;
          p_q     <= '0;
          c_q     <= '0;
          j_q     <= '0;
          pbase_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // Memory port selection
  always_comb begin
    pt_we  = accept && item_i.action == kll_pkg::ACT_LOAD;
    pt_wa  = cursor_q;
    pt_ra  = (state_q == ST_SELECT) ? sbase_q + kll_pkg::PtAw'(j_q)
                                     : pbase_q + kll_pkg::PtAw'(j_q);

    cen_we = selv_q || state_q == ST_UPD_WR;
    cen_wa = selv_q ? selwa_q : {c_q, j_q};
    cen_wd = selv_q ? pt_rd_q : m_q;
    cen_ra = {c_q, j_q};

    sum_we = accv_q || state_q == ST_ZERO;
    sum_wa = accv_q ? accwa_q : {c_q, j_q};
    sum_wd = accv_q ? sum_rd_q + {{32{pt_rd_q[31]}}, pt_rd_q} : 64'sd0;
    sum_ra = (state_q == ST_ACC_J) ? {a_q, j_q} : {c_q, j_q};

    asg_we = (state_q == ST_CLEAR) || (s3v_q && t3_q.last && t3_q.last_c);
    asg_wa = (state_q == ST_CLEAR) ? clr_q : t3_q.p;
    asg_wd = (state_q == ST_CLEAR) ? 4'd0 : 4'(win_c);
    asg_ra = (state_q == ST_ACC_A) ? p_q : item_i.point_index;

    cnt_ix = (state_q == ST_ACC_W) ? asg_rd_q[kll_pkg::CidxW-1:0] : c_q;
    cnt_rd = cnt_q[cnt_ix];
  end

  // Distance arithmetic
  always_comb begin
    diff    = {pt_rd_q[31], pt_rd_q} - {cen_rd_q[31], cen_rd_q};
    mag_w   = diff[32] ? 33'(-diff) : 33'(diff);
    acc_sum = {1'b0, (t3_q.first ? 64'd0 : acc_q)} + {1'b0, sq_q};
    acc_sat = acc_sum[64] ? '1 : acc_sum[63:0];
    better  = (t3_q.c == '0) || (acc_sat < best_q);
    win_c   = better ? t3_q.c : bi_q;
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (pt_we) pt_mem[pt_wa] <= item_i.coordinate;
    pt_rd_q <= pt_mem[pt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cen_we) cen_mem[cen_wa] <= cen_wd;
    cen_rd_q <= cen_mem[cen_ra];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_wa] <= sum_wd;
    sum_rd_q <= sum_mem[sum_ra];
  end

  always_ff @(posedge clk_i) begin
    if (asg_we) asg_mem[asg_wa] <= asg_wd;
    asg_rd_q <= asg_mem[asg_ra];
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept && item_i.action == kll_pkg::ACT_SELECT) begin
      sbase_q <= sel_prod[kll_pkg::PtAw-1:0];
      slot_q  <= item_i.cluster_slot;
    end
    res_pt_q <= item_i.point_index;
    selwa_q  <= {slot_q, j_q};
    accwa_q  <= {a_q, j_q};

    // Tag each distance term at issue
    t1_q.first  <= j_q == '0;
    t1_q.last   <= j_last;
    t1_q.last_c <= c_last;
    t1_q.c      <= c_q;
    t1_q.p      <= p_q;
    t2_q        <= t1_q;
    t3_q        <= t2_q;
    mag_q       <= mag_w[31:0];
    sq_q        <= mag_q * mag_q;

    // Accumulate and keep the nearest centroid
    if (s3v_q) begin
      acc_q <= acc_sat;
      if (t3_q.last && better) begin
        best_q <= acc_sat;
        bi_q   <= t3_q.c;
      end
    end

    // Cluster counts
    if (state_q == ST_ZERO && j_q == '0) begin
      cnt_q[c_q] <= '0;
    end else if (state_q == ST_ACC_W) begin
      cnt_q[cnt_ix] <= cnt_rd + 1'b1;
    end
    if (state_q == ST_ACC_W) a_q <= asg_rd_q[kll_pkg::CidxW-1:0];

    // Mean of the cluster
    if (state_q == ST_UPD_GO) begin
      cen_old_q <= cen_rd_q;
      if (cnt_rd == '0) m_q <= 32'sd0;
    end
    if (state_q == ST_UPD_DIV && div_done) m_q <= div_quot[31:0];
  end

  assign div_start = state_q == ST_UPD_GO && cnt_rd != '0;

  kll_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_rd_q),
    .divisor_i  (cnt_rd),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  assign res_valid_o           = res_valid_q;
  assign res_o.assigned_cluster = asg_rd_q;
  assign res_o.read_point      = res_pt_q;

endmodule

@@ hdl/kll_div.sv @@
// Iterative signed 64-bit by unsigned 11-bit divider, one quotient bit a cycle.
// Truncates toward zero. Depends on nothing outside this file.
module kll_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] dividend_i,
  input  logic [10:0]        divisor_i,
  output logic               done_o,
  output logic signed [63:0] quotient_o
);

  logic        busy_q;
  logic [5:0]  cnt_q;
  logic        done_q;
  logic        neg_q;
  logic [63:0] work_q;
  logic [10:0] rem_q;
  logic [10:0] div_q;
  logic [11:0] shifted;
  logic [11:0] diff;
  logic        ge;

  // Shift one dividend bit into the partial remainder and try a subtract
  always_comb begin
    shifted = {rem_q, work_q[63]};
    ge      = shifted >= {1'b0, div_q};
    diff    = shifted - {1'b0, div_q};
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[63];
      work_q <= dividend_i[63] ? (64'd0 - dividend_i) : dividend_i;
      rem_q  <= '0;
      div_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[10:0] : shifted[10:0];
      work_q <= {work_q[62:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? (64'sd0 - $signed(work_q)) : $signed(work_q);

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the k-means clustering block kmeans_lloyd_clustering.
// Depends on kll_pkg and the block's RTL; predicts every read word from a local model.
`timescale 1ns / 100ps

module testbench;
  import kll_pkg::*;

  localparam int unsigned StoreSize  = MaxPoints * MaxDims;
  localparam longint      CycleLimit = 20_000_000;

  // Tracks block state, predicts read words and checks them in order
  class cluster_scoreboard;
    logic signed [31:0] points [StoreSize];
    logic signed [31:0] centroids [MaxClusters * MaxDims];
    logic [3:0]         assignment [MaxPoints];
    int unsigned        cursor;
    bit                 wrapped;
    logic [10:0]        npts_reg;
    logic [4:0]         nclus_reg;
    logic [4:0]         ndims_reg;
    logic [15:0]        iter_reg;
    result_t            pending_q [$];
    int                 mismatches;
    int                 checked;

    function new();
      foreach (assignment[i]) assignment[i] = '0;
      cursor = 0;
      wrapped = 0;
      npts_reg = 11'd1;
      nclus_reg = 5'd1;
      ndims_reg = 5'd1;
      iter_reg = 16'd100;
      mismatches = 0;
      checked = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned eff_points();
      return clamp(npts_reg, MaxPoints);
    endfunction

    function int unsigned eff_clusters();
      return clamp(nclus_reg, MaxClusters);
    endfunction

    function int unsigned eff_dims();
      return clamp(ndims_reg, MaxDims);
    endfunction

    // Number of leading store entries that hold a loaded coordinate
    function int unsigned filled();
      return wrapped ? StoreSize : cursor;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] data);
      case (idx)
        CFG_NUM_POINTS:   npts_reg = data[10:0];
        CFG_NUM_CLUSTERS: nclus_reg = data[4:0];
        CFG_NUM_DIMS:     ndims_reg = data[4:0];
        CFG_MAX_ITER:     iter_reg = data;
        default: ;
      endcase
    endfunction

    // Saturating squared distance between point p and centroid c
    function bit [63:0] sq_dist(int unsigned p, int unsigned c, int unsigned d);
      bit [63:0] acc;
      bit [63:0] mag;
      bit [63:0] sq;
      longint    diff;
      acc = '0;
      for (int unsigned j = 0; j < d; j++) begin
        diff = longint'(points[p * d + j]) - longint'(centroids[c * MaxDims + j]);
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        sq = mag * mag;
        acc = (acc > ~64'd0 - sq) ? ~64'd0 : acc + sq;
      end
      return acc;
    endfunction

    // Assignment and update rounds until stable or out of rounds
    function void cluster_rounds();
      int unsigned n, k, d, bi;
      bit [63:0]   best, dist_val;
      longint      sums [MaxClusters * MaxDims];
      int unsigned counts [MaxClusters];
      bit          stable;
      n = eff_points();
      k = eff_clusters();
      d = eff_dims();
      for (int unsigned r = 0; r < iter_reg; r++) begin
        stable = 1;
        for (int unsigned p = 0; p < n; p++) begin
          best = '0;
          bi = 0;
          for (int unsigned c = 0; c < k; c++) begin
            dist_val = sq_dist(p, c, d);
            if (c == 0 || dist_val < best) begin
              best = dist_val;
              bi = c;
            end
          end
          assignment[p] = bi[3:0];
        end
        foreach (sums[i]) sums[i] = 0;
        foreach (counts[i]) counts[i] = 0;
        for (int unsigned p = 0; p < n; p++) begin
          counts[assignment[p]]++;
          for (int unsigned j = 0; j < d; j++)
            sums[assignment[p] * MaxDims + j] += longint'(points[p * d + j]);
        end
        for (int unsigned c = 0; c < k; c++) begin
          for (int unsigned j = 0; j < d; j++) begin
            sums[c * MaxDims + j] = (counts[c] != 0) ?
                sums[c * MaxDims + j] / longint'(counts[c]) : 0;
            if (longint'(centroids[c * MaxDims + j]) != sums[c * MaxDims + j]) stable = 0;
          end
        end
        if (stable) break;
        for (int unsigned c = 0; c < k; c++)
          for (int unsigned j = 0; j < d; j++)
            centroids[c * MaxDims + j] = sums[c * MaxDims + j][31:0];
      end
    endfunction

    // Apply one accepted input word
    function void note_word(item_t it);
      int unsigned d;
      result_t     exp_r;
      case (it.action)
        ACT_LOAD: begin
          points[cursor] = it.coordinate;
          cursor++;
          if (cursor == StoreSize) begin
            cursor = 0;
            wrapped = 1;
          end
        end
        ACT_SELECT: begin
          d = eff_dims();
          for (int unsigned j = 0; j < d; j++)
            centroids[it.cluster_slot * MaxDims + j] =
                points[(it.point_index * d + j) % StoreSize];
        end
        ACT_START: cluster_rounds();
        default: begin
          exp_r.assigned_cluster = assignment[it.point_index];
          exp_r.read_point = it.point_index;
          pending_q.push_back(exp_r);
        end
      endcase
    endfunction

    // Compare one result word with the oldest prediction
    function void check_word(result_t got);
      result_t exp_r;
      checked++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result word cluster=%0d point=%0d",
                   got.assigned_cluster, got.read_point);
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.assigned_cluster !== exp_r.assigned_cluster ||
          got.read_point !== exp_r.read_point) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: point %0d expected cluster=%0d point=%0d, got cluster=%0d point=%0d",
                   exp_r.read_point, exp_r.assigned_cluster, exp_r.read_point,
                   got.assigned_cluster, got.read_point);
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  item_t       item_i;
  logic        res_valid_o;
  result_t     res_o;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;

  cluster_scoreboard sb;
  longint            cycles = 0;
  int                words_sent;
  int                runs_started;
  bit                no_idle;

  kmeans_lloyd_clustering DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .item_i     (item_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Check every strobed result word
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_word(res_o);
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ERROR: timeout after %0d cycles", cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Present one word after a gap and hold it until accepted
  task automatic send_word(item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!busy_o) break;
    end
    sb.note_word(it);
    words_sent++;
  endtask

  task automatic send_load(logic [31:0] value);
    item_t it;
    it = '0;
    it.action = ACT_LOAD;
    it.coordinate = value;
    it.point_index = 10'($urandom);
    it.cluster_slot = 4'($urandom);
    send_word(it);
  endtask

  task automatic send_pick(int unsigned act, int unsigned pidx, int unsigned slot);
    item_t it;
    it.action = action_e'(act);
    it.coordinate = $urandom;
    it.point_index = pidx[9:0];
    it.cluster_slot = slot[3:0];
    send_word(it);
  endtask

  // Drop start, then wait until the block is idle and every read word is back
  task automatic drain();
    start_i <= 1'b0;
    repeat (4) @(posedge clk_i);
    while (busy_o || sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all four registers back to back while idle
  task automatic set_regs(int unsigned np, int unsigned nc, int unsigned nd, int unsigned mi);
    logic [15:0] vals [4];
    vals = '{np[15:0], nc[15:0], nd[15:0], mi[15:0]};
    drain();
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= 2'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.write_reg(2'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
  endtask

  function logic [31:0] draw_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 40)) - 20) <<< 16;
      default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
    endcase
  endfunction

  // One clustering job: registers, coordinates, seeds, early reads, start, then reads
  task automatic run_job(int unsigned np, int unsigned nc, int unsigned nd, int unsigned mi);
    int unsigned n, k, d, need, pmax;
    set_regs(np, nc, nd, mi);
    no_idle = ($urandom_range(0, 2) == 0);
    n = sb.eff_points();
    k = sb.eff_clusters();
    d = sb.eff_dims();
    need = (sb.filled() < n * d) ? n * d - sb.filled() : 0;
    repeat (need + $urandom_range(0, 2 * d)) send_load(draw_coord());
    pmax = sb.filled() / d;
    if (pmax > MaxPoints) pmax = MaxPoints;
    for (int unsigned c = 0; c < k; c++)
      send_pick(ACT_SELECT, $urandom_range(0, pmax - 1), c);
    repeat ($urandom_range(0, 2))
      send_pick(ACT_SELECT, $urandom_range(0, pmax - 1), $urandom_range(0, 15));
    repeat ($urandom_range(0, 3)) send_pick(ACT_READ, $urandom_range(0, 1023), 0);
    send_pick(ACT_START, $urandom, $urandom);
    runs_started++;
    repeat ($urandom_range(15, 35)) begin
      if ($urandom_range(0, 3) == 0) send_pick(ACT_READ, $urandom_range(0, 1023), 0);
      else send_pick(ACT_READ, $urandom_range(0, n - 1), 0);
    end
  endtask

  initial begin
    sb = new();
    words_sent = 0;
    runs_started = 0;
    no_idle = 0;
    rst_ni <= 1'b0;
    start_i <= 1'b0;
    item_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= '0;
    cfg_data_i <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme coordinates, tied seeds, slot beyond range, saturating distances
    set_regs(3, 2, 2, 65535);
    send_load(32'h7FFF_FFFF);
    send_load(32'h8000_0000);
    send_load(32'h0000_0000);
    send_load(32'hFFFF_FFFF);
    send_load(32'h8000_0000);
    send_load(32'h7FFF_FFFF);
    send_pick(ACT_READ, 0, 0);
    send_pick(ACT_SELECT, 0, 0);
    send_pick(ACT_SELECT, 0, 1);
    send_pick(ACT_SELECT, 2, 15);
    send_pick(ACT_START, 0, 0);
    send_pick(ACT_READ, 0, 0);
    send_pick(ACT_READ, 2, 0);
    send_pick(ACT_READ, 1023, 0);
    send_pick(ACT_SELECT, 0, 0);
    send_pick(ACT_SELECT, 2, 1);
    send_pick(ACT_START, 0, 0);
    send_pick(ACT_READ, 1, 0);
    send_pick(ACT_READ, 2, 0);
    // Zero rounds leave assignments alone; zero register values clamp up
    set_regs(16'hF800, 16'hFFE0, 16'hFFE0, 0);
    send_pick(ACT_SELECT, 1, 0);
    send_pick(ACT_START, 0, 0);
    send_pick(ACT_READ, 0, 0);
    send_pick(ACT_READ, 2, 0);
    runs_started += 3;

    // Random jobs on small sizes
    while (words_sent < 900)
      run_job($urandom_range(1, 24), ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16)
              : $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 6));

    // Largest sizes once each through out-of-range register values, then a zero point count and long round limits
    run_job(16'hFFFF, 2, 1, 2);
    run_job(4, 31, 31, 3);
    run_job(0, 3, 4, 65535);
    run_job(1, 1, 1, 65535);
    while (words_sent < 1600)
      run_job($urandom_range(1, 24), $urandom_range(1, 6), $urandom_range(1, 6),
              $urandom_range(0, 6));

    drain();
    repeat (20) @(posedge clk_i);
    $display("Sent %0d words over %0d clustering runs; checked %0d read words.",
             words_sent, runs_started, sb.checked);
    $display("Mismatches: %0d, predictions left over: %0d", sb.mismatches,
             sb.pending_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
